### rtl/imu_serial_frame_parser_defines.svh
// Assertion macros used by the serial frame parser top level.
`ifndef IMU_SERIAL_FRAME_PARSER_DEFINES_SVH
`define IMU_SERIAL_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define ISFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define ISFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/isfp_pkg.sv
// Shared types and constants of the serial frame parser.
package isfp_pkg;

  localparam int WIN_BYTES = 10;   // bytes kept besides the incoming one
  localparam int SKIP_W    = 4;
  localparam logic [SKIP_W-1:0] SKIP_AFTER_FRAME = SKIP_W'(10);

  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACCEL  = 8'h51;
  localparam logic [7:0] TYPE_RATE   = 8'h52;
  localparam logic [7:0] TYPE_ANGLE  = 8'h53;

  // Queue between front and back; depth is a power of two.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_ANGLE = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  // One detected frame: its kind and three raw little-endian words.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
  } frame_t;

endpackage

### rtl/isfp_front.sv
// Byte window, skip counter and frame detection.
module isfp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output logic              push,
  output isfp_pkg::frame_t  frame
);
  import isfp_pkg::*;

  logic [7:0]        win_r   [WIN_BYTES];
  logic [7:0]        win_nxt [WIN_BYTES];
  logic [SKIP_W-1:0] skip_r, skip_nxt;
  logic [7:0]        sum;
  logic              found;
  kind_t             kind;

  // Eight-bit checksum over the ten bytes ahead of the incoming one.
  always_comb begin
    sum = 8'd0;
    for (int i = 0; i < WIN_BYTES; i++) begin
      sum = sum + win_r[i];
    end
  end

  always_comb begin
    unique case (win_r[1])
      TYPE_ACCEL: kind = KIND_ACCEL;
      TYPE_RATE:  kind = KIND_RATE;
      TYPE_ANGLE: kind = KIND_ANGLE;
      default:    kind = KIND_OTHER;
    endcase
  end

  assign found = accept && (skip_r == '0) && (win_r[0] == HEADER_BYTE) && (sum == rx_byte);
  assign push  = found;

  always_comb begin
    frame.kind = kind;
    frame.w0   = {win_r[3], win_r[2]};
    frame.w1   = {win_r[5], win_r[4]};
    frame.w2   = {win_r[7], win_r[6]};
  end

  always_comb begin
    for (int i = 0; i < WIN_BYTES - 1; i++) begin
      win_nxt[i] = win_r[i+1];
    end
    win_nxt[WIN_BYTES-1] = rx_byte;
  end

  always_comb begin
    skip_nxt = skip_r;
    if (accept) begin
      if (skip_r != '0) begin
        skip_nxt = skip_r - SKIP_W'(1);
      end else if (found) begin
        skip_nxt = SKIP_AFTER_FRAME;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= '0;
      for (int i = 0; i < WIN_BYTES; i++) begin
        win_r[i] <= 8'd0;
      end
    end else if (accept) begin
      skip_r <= skip_nxt;
      for (int i = 0; i < WIN_BYTES; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

endmodule

### rtl/isfp_queue.sv
// Short frame queue between detection and record update.
module isfp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  isfp_pkg::frame_t  push_frame,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output isfp_pkg::frame_t  head
);
  import isfp_pkg::*;

  frame_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/isfp_back.sv
// Held sensor counts, ready flags and the result register.
module isfp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                publish_en,
  input  logic                q_empty,
  input  isfp_pkg::frame_t    head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          frame_kind,
  output logic signed [15:0]  accel_fwd,
  output logic signed [16:0]  accel_left,
  output logic signed [15:0]  accel_up,
  output logic signed [15:0]  rate_fwd,
  output logic signed [16:0]  rate_left,
  output logic signed [15:0]  rate_up,
  output logic signed [15:0]  angle_roll,
  output logic signed [16:0]  angle_pitch,
  output logic signed [15:0]  angle_yaw,
  output logic                record_complete
);
  import isfp_pkg::*;

  logic [15:0] accel_r [3];
  logic [15:0] rate_r  [3];
  logic [15:0] angle_r [3];
  logic [2:0]  flags_r, flags_nxt, flags_set;
  logic        complete_nxt;
  logic        valid_r;
  kind_t       kind_r;
  logic        complete_r;

  // Held registers change only on a pop, which only happens when no result is
  // held or the current one leaves, so they serve directly as result payload.
  assign pop = !q_empty && (!valid_r || out_ready);

  always_comb begin
    flags_set = 3'b000;
    unique case (head.kind)
      KIND_ACCEL: flags_set = 3'b001;
      KIND_RATE:  flags_set = 3'b010;
      KIND_ANGLE: flags_set = 3'b100;
      default:    flags_set = 3'b000;
    endcase
    flags_nxt    = flags_r | flags_set;
    complete_nxt = publish_en && (flags_nxt == 3'b111);
    if (complete_nxt) begin
      flags_nxt = 3'b000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      flags_r    <= 3'b000;
      kind_r     <= KIND_OTHER;
      complete_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        accel_r[i] <= 16'd0;
        rate_r[i]  <= 16'd0;
        angle_r[i] <= 16'd0;
      end
    end else begin
      if (pop) begin
        valid_r    <= 1'b1;
        flags_r    <= flags_nxt;
        kind_r     <= head.kind;
        complete_r <= complete_nxt;
        unique case (head.kind)
          KIND_ACCEL: begin
            accel_r[0] <= head.w0;
            accel_r[1] <= head.w1;
            accel_r[2] <= head.w2;
          end
          KIND_RATE: begin
            rate_r[0] <= head.w0;
            rate_r[1] <= head.w1;
            rate_r[2] <= head.w2;
          end
          KIND_ANGLE: begin
            angle_r[0] <= head.w0;
            angle_r[1] <= head.w1;
            angle_r[2] <= head.w2;
          end
          default: begin
          end
        endcase
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = valid_r;
  assign frame_kind      = kind_r;
  assign record_complete = complete_r;

  // Forward takes sensor Y, up takes Z, left takes the negated X.
  assign accel_fwd   = signed'(accel_r[1]);
  assign accel_up    = signed'(accel_r[2]);
  assign accel_left  = signed'(17'd0 - {accel_r[0][15], accel_r[0]});
  assign rate_fwd    = signed'(rate_r[1]);
  assign rate_up     = signed'(rate_r[2]);
  assign rate_left   = signed'(17'd0 - {rate_r[0][15], rate_r[0]});
  assign angle_roll  = signed'(angle_r[1]);
  assign angle_yaw   = signed'(angle_r[2]);
  assign angle_pitch = signed'(17'd0 - {angle_r[0][15], angle_r[0]});

endmodule

### rtl/imu_serial_frame_parser.sv
// IMU serial frame parser top level: byte window front, frame queue, record back.
// The block takes one received serial byte per cycle and finds 11-byte sensor
// frames: a 0x55 header followed by a type byte, six data bytes, two more
// bytes and an 8-bit sum of the first ten bytes. After a good frame the next
// ten bytes pass through unchecked; a bad sum just moves the search on by one
// byte. Each good frame gives one result. Type 0x51, 0x52 and 0x53 frames load
// acceleration, angular rate or angle (three little-endian signed counts),
// remapped to forward (sensor Y), left (negated sensor X, 17 bits so that
// -32768 turns into +32768) and up (sensor Z); angle maps roll, negated
// pitch and yaw the same way. All nine held counts go out with every result,
// along with the frame kind (3 for any other type). With publish enabled, a
// frame after which all three kinds have arrived since the last record is
// flagged record_complete and the ready flags clear; with publish disabled
// flags only accumulate. Throughput is one byte per cycle while the queue is
// not full: the front compares the header and a ten-byte checksum against the
// incoming byte in the cycle it is accepted. A good frame is written into a
// two-entry queue and from there into the result register. in_ready drops
// only while the queue is full, which needs the result side to stall across
// two frames; the result register frees on the same edge its request is
// taken, so back-to-back results flow.
// Write cfg_wdata with cfg_we while the block is idle; reset sets publish on.
`include "imu_serial_frame_parser_defines.svh"
module imu_serial_frame_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_frame_kind,
  output logic signed [15:0]  out_accel_fwd,
  output logic signed [16:0]  out_accel_left,
  output logic signed [15:0]  out_accel_up,
  output logic signed [15:0]  out_rate_fwd,
  output logic signed [16:0]  out_rate_left,
  output logic signed [15:0]  out_rate_up,
  output logic signed [15:0]  out_angle_roll,
  output logic signed [16:0]  out_angle_pitch,
  output logic signed [15:0]  out_angle_yaw,
  output logic                out_record_complete
);
  import isfp_pkg::*;

  logic   publish_r;
  logic   in_accept;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;
  frame_t push_frame;
  frame_t head;

  // Publish register: written whenever the enable is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      publish_r <= 1'b1;
    end else if (cfg_we) begin
      publish_r <= cfg_wdata;
    end
  end

  // Accept a byte whenever the queue can take a frame.
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  isfp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .rx_byte (in_rx_byte),
    .push    (push),
    .frame   (push_frame)
  );

  isfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (head)
  );

  isfp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .publish_en      (publish_r),
    .q_empty         (q_empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .frame_kind      (out_frame_kind),
    .accel_fwd       (out_accel_fwd),
    .accel_left      (out_accel_left),
    .accel_up        (out_accel_up),
    .rate_fwd        (out_rate_fwd),
    .rate_left       (out_rate_left),
    .rate_up         (out_rate_up),
    .angle_roll      (out_angle_roll),
    .angle_pitch     (out_angle_pitch),
    .angle_yaw       (out_angle_yaw),
    .record_complete (out_record_complete)
  );

  // A frame never lands on a full queue.
  `ISFP_ASSERT_NOW(a_push_not_full, push, !q_full, "frame pushed into full queue")
  // The skip window keeps frames at least eleven bytes apart.
  `ISFP_ASSERT_NEXT(a_push_spacing, push, !push, "frames detected on consecutive bytes")
  // A result only leaves the queue when the result register can take it.
  `ISFP_ASSERT_NOW(a_pop_slot, pop, !q_empty && (!out_valid || out_ready), "pop without slot")

endmodule
